// File: rtl/edfh_pkg.sv
package edfh_pkg;

    // configured length limit; the counter itself is 16 bits wide
    localparam logic [31:0] MaxLength  = 32'd65535;
    localparam logic [15:0] CountLimit =
        (MaxLength > 32'd65535) ? 16'hFFFF : MaxLength[15:0];

    localparam logic [31:0] FnvBasis = 32'd2166136261;
    localparam logic [31:0] FnvPrime = 32'd16777619;

    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChLowerN    = 8'h6E;
    localparam logic [7:0] ChLowerE    = 8'h65;
    localparam logic [7:0] ChLowerT    = 8'h74;
    localparam logic [7:0] ChNewline   = 8'h0A;
    localparam logic [7:0] ChEscape    = 8'h1B;
    localparam logic [7:0] ChTab       = 8'h09;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic        done_res;
        logic [31:0] hash_value;
        logic [15:0] decoded_length;
    } t_out_item;

    typedef struct packed {
        logic     step;
        t_in_item item;
    } t_core_ctl;

    function automatic logic [7:0] translate_escape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            ChBackslash: r = ChBackslash;
            ChLowerN:    r = ChNewline;
            ChLowerE:    r = ChEscape;
            ChLowerT:    r = ChTab;
            default:     r = c;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/edfh_core.sv
module edfh_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  edfh_pkg::t_core_ctl   i_ctl,
    output edfh_pkg::t_out_item   o_res
);

    logic        r_esc;
    logic [31:0] r_hash;
    logic [15:0] r_count;

    logic        n_esc;
    logic [31:0] n_hash;
    logic [15:0] n_count;

    logic        dec_valid;
    logic [7:0]  dec_byte;
    logic [31:0] hash_upd;
    logic [15:0] count_upd;

    always_comb begin
        dec_valid = 1'b0;
        dec_byte  = 8'h00;
        n_esc     = r_esc;
        if (r_esc) begin
            dec_byte  = edfh_pkg::translate_escape(i_ctl.item.in_byte);
            dec_valid = 1'b1;
            n_esc     = 1'b0;
        end else if (i_ctl.item.in_byte == edfh_pkg::ChBackslash) begin
            n_esc = 1'b1;
        end else begin
            dec_byte  = i_ctl.item.in_byte;
            dec_valid = 1'b1;
        end

        hash_upd  = r_hash;
        count_upd = r_count;
        if (dec_valid) begin
            hash_upd = (r_hash ^ {24'h000000, dec_byte}) * edfh_pkg::FnvPrime;
            if (r_count < edfh_pkg::CountLimit) begin
                count_upd = r_count + 16'd1;
            end
        end

        o_res.byte_valid     = dec_valid;
        o_res.out_byte       = dec_byte;
        o_res.done_res       = i_ctl.item.is_last;
        o_res.hash_value     = i_ctl.item.is_last ? hash_upd : 32'h0;
        o_res.decoded_length = i_ctl.item.is_last ? count_upd : 16'h0;

        // end of string returns the state to its start values
        if (i_ctl.item.is_last) begin
            n_esc   = 1'b0;
            n_hash  = edfh_pkg::FnvBasis;
            n_count = 16'h0;
        end else begin
            n_hash  = hash_upd;
            n_count = count_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= 1'b0;
            r_hash  <= edfh_pkg::FnvBasis;
            r_count <= 16'h0;
        end else if (i_ctl.step) begin
            r_esc   <= n_esc;
            r_hash  <= n_hash;
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/escape_decode_fnv1a_hash.sv
// escape decoder with running fnv-1a hash, one raw string byte per transaction
//
// input channel: i_valid / o_stall carry i_item (source byte and last flag);
// output channel: o_valid / i_stall carry o_item, exactly one result per input.
// a result marks whether a decoded byte is present; on the last byte of a
// string it also carries the final 32-bit hash and the saturating length.
// path: a byte taken from the input channel sits in the input register and is
// then decoded and hashed into the result register, which drives o_valid and
// o_item; a stall at the output can hold it in the input register.
// throughput: one byte per cycle while i_stall is low, set by the hash feedback
// (xor and constant multiply of the running hash), which is combinational.
// stall: while a result waits under i_stall the input register still takes
// one more byte; o_stall rises only when both registers are occupied.
// reset (synchronous, active low) empties both registers, clears a pending
// escape and restores the hash to the offset basis and the length to zero;
// escape, hash and length are restored likewise after every byte marked last.
module escape_decode_fnv1a_hash (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  edfh_pkg::t_in_item    i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output edfh_pkg::t_out_item   o_item
);

    logic                 r_in_vld;
    edfh_pkg::t_in_item   r_in;
    logic                 r_out_vld;
    edfh_pkg::t_out_item  r_out;

    logic                 adv_out;
    logic                 step;
    logic                 take_in;
    edfh_pkg::t_core_ctl  core_ctl;
    edfh_pkg::t_out_item  core_res;

    assign adv_out = !r_out_vld || !i_stall;
    assign step    = r_in_vld && adv_out;
    assign o_stall = r_in_vld && !adv_out;
    assign take_in = i_valid && !o_stall;

    assign core_ctl.step = step;
    assign core_ctl.item = r_in;

    edfh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (take_in) begin
                r_in_vld <= 1'b1;
            end else if (step) begin
                r_in_vld <= 1'b0;
            end
            if (step) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in <= i_item;
        end
        if (step) begin
            r_out <= core_res;
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

endmodule

// File: rtl/edfh_checker.sv
module edfh_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_stall,
    input edfh_pkg::t_out_item  o_item
);

    // a result held back by the receiver keeps its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // totals only appear on the closing transaction of a string
    a_totals_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.done_res |->
            o_item.hash_value == 32'h0 && o_item.decoded_length == 16'h0)
        else $error("totals present before end of string");

    a_no_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.byte_valid |-> o_item.out_byte == 8'h00)
        else $error("dropped backslash produced a byte");

    a_empty_basis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.done_res && o_item.decoded_length == 16'h0 |->
            o_item.hash_value == edfh_pkg::FnvBasis && !o_item.byte_valid)
        else $error("empty string hash differs from offset basis");

endmodule

bind escape_decode_fnv1a_hash edfh_checker u_edfh_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);
